// ----- sv/swr_pkg.sv -----
// package for the sampling-without-replacement block: sizes, types and shared helpers
package swr_pkg;

  localparam int MaxPopulation = 1024;
  localparam int AddrW         = $clog2(MaxPopulation);
  localparam int CntW          = AddrW + 1;
  localparam int FracW         = 32;
  localparam int SizeW         = 11;
  localparam int PickW         = 10;
  localparam int ProdW         = CntW + FracW;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [FracW-1:0] frac_t;
  typedef logic [SizeW-1:0] size_t;
  typedef logic [PickW-1:0] pick_t;
  typedef logic [ProdW-1:0] prod_t;

  localparam size_t SizeReset = size_t'(1024);

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic fill_start;
    logic fill_step;
    logic fill_done;
    logic mul;
    logic pick;
    logic capt;
    logic advance;
    logic shift;
    logic load_out;
  } swr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic fill_end;
    logic count_zero;
    logic has_next;
  } swr_status_t;

  // population size saturated to the list depth
  function automatic cnt_t cap_size(input size_t n);
    cnt_t r;
    if (CntW'(n) > cnt_t'(MaxPopulation)) begin
      r = cnt_t'(MaxPopulation);
    end else begin
      r = cnt_t'(n);
    end
    return r;
  endfunction

endpackage

// ----- sv/swr_ctrl.sv -----
// controller state machine: fill passes, draw sequence, shift loop and output hand-off
module swr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                restart,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  swr_pkg::swr_status_t status,
  output swr_pkg::swr_cmd_t    cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_CAPT  = 3'd5;
  localparam logic [2:0] S_SHIFT = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT, S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_end) begin
          cmd.fill_done = 1'b1;
          state_next    = (state == S_INIT) ? S_IDLE : S_MUL;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (restart) begin
            cmd.fill_start = 1'b1;
            state_next     = S_FILL;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.count_zero ? S_DONE : S_PICK;
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_CAPT;
      end
      S_CAPT: begin
        cmd.capt = 1'b1;
        if (status.has_next) begin
          cmd.advance = 1'b1;
          state_next  = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.has_next) begin
          cmd.advance = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output valid holds until the transaction completes
  assign out_valid_next = cmd.load_out | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- sv/swr_datapath.sv -----
// datapath: remaining list memory, count, position multiplier, shift pointer and output register
module swr_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  swr_pkg::size_t        population_size,
  input  swr_pkg::frac_t        uniform_fraction,
  input  swr_pkg::swr_cmd_t     cmd,
  output swr_pkg::swr_status_t  status,
  output swr_pkg::pick_t        picked_index,
  output logic                  exhausted
);

  logic [swr_pkg::AddrW-1:0] mem [swr_pkg::MaxPopulation];

  swr_pkg::size_t size_reg;
  swr_pkg::cnt_t  count;
  swr_pkg::cnt_t  fill_ptr;
  swr_pkg::cnt_t  fill_len;
  swr_pkg::frac_t frac;
  swr_pkg::prod_t prod;
  swr_pkg::addr_t src;
  swr_pkg::addr_t rdata;
  swr_pkg::addr_t picked;
  logic           exh;

  swr_pkg::addr_t pos;
  swr_pkg::cnt_t  src_plus1;
  swr_pkg::addr_t rd_addr;
  logic           rd_en;
  logic           wr_en;
  swr_pkg::addr_t wr_addr;
  swr_pkg::addr_t wr_data;
  logic           fill_wr;

  // draw position is the top bits of count times fraction
  assign pos       = prod[swr_pkg::FracW +: swr_pkg::AddrW];
  assign src_plus1 = swr_pkg::CntW'(src) + swr_pkg::CntW'(1);

  assign status.fill_end   = (fill_ptr == fill_len);
  assign status.count_zero = (count == '0);
  assign status.has_next   = (src_plus1 < count);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= swr_pkg::SizeReset;
    end else if (cfg_valid) begin
      size_reg <= population_size;
    end
  end

  // fill pointer and remaining count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_ptr <= '0;
      fill_len <= swr_pkg::cap_size(swr_pkg::SizeReset);
      count    <= swr_pkg::cap_size(swr_pkg::SizeReset);
    end else begin
      if (cmd.fill_start) begin
        fill_ptr <= '0;
        fill_len <= swr_pkg::cap_size(size_reg);
      end else if (fill_wr) begin
        fill_ptr <= fill_ptr + swr_pkg::CntW'(1);
      end
      if (cmd.fill_done) begin
        count <= fill_len;
      end else if (cmd.load_out && !exh) begin
        count <= count - swr_pkg::CntW'(1);
      end
    end
  end

  // item capture, position product and empty flag
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      frac <= uniform_fraction;
    end
    if (cmd.mul) begin
      prod <= swr_pkg::ProdW'(count) * swr_pkg::ProdW'(frac);
      exh  <= (count == '0);
    end
  end

  // shift pointer walks from the pick position toward the end of the list
  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      src <= pos;
    end else if (cmd.advance) begin
      src <= src_plus1[swr_pkg::AddrW-1:0];
    end
    if (cmd.capt) begin
      picked <= rdata;
    end
  end

  // memory port selection
  assign fill_wr = cmd.fill_step & ~status.fill_end;
  assign rd_en   = cmd.pick | cmd.advance;
  assign rd_addr = cmd.pick ? pos : src_plus1[swr_pkg::AddrW-1:0];
  assign wr_en   = fill_wr | cmd.shift;
  assign wr_addr = fill_wr ? fill_ptr[swr_pkg::AddrW-1:0] : src - swr_pkg::AddrW'(1);
  assign wr_data = fill_wr ? fill_ptr[swr_pkg::AddrW-1:0] : rdata;

  // list memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      picked_index <= exh ? '0 : swr_pkg::PickW'(picked);
      exhausted    <= exh;
    end
  end

endmodule

// ----- sv/sample_without_replacement.sv -----
// a transaction runs multiply, pick, capture, then shifts the entries after pos, the drawn place;
// an empty list skips to an exhausted result; a stalled output adds its wait to either
// a restart adds a fill pass of min(population_size, 1024) entries before the draw
// throughput: one item at a time, bounded by the one-entry-per-cycle shift through the list memory
// reset: synchronous, active high; then a fill pass loads the list, input stalled
// configuration writes are taken on every cycle and act at the next restart
module sample_without_replacement (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  swr_pkg::frac_t       uniform_fraction,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output swr_pkg::pick_t       picked_index,
  output logic                 exhausted,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  swr_pkg::size_t       population_size
);

  swr_pkg::swr_cmd_t    cmd;
  swr_pkg::swr_status_t status;

  assign cfg_ready = 1'b1;

  // controller
  swr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .restart   (restart),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  swr_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .population_size  (population_size),
    .uniform_fraction (uniform_fraction),
    .cmd              (cmd),
    .status           (status),
    .picked_index     (picked_index),
    .exhausted        (exhausted)
  );

`ifndef SYNTHESIS
  // an accepted transaction keeps the input stalled on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // an exhausted result always carries index zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && exhausted) |-> (picked_index == '0))
    else $error("exhausted result with nonzero index");

  // sequencing commands never overlap
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.fill_step, cmd.mul, cmd.pick, cmd.shift, cmd.load_out}))
    else $error("overlapping datapath commands");

  // the output register is loaded only when it is free or being emptied
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result overwritten before transfer");
`endif

endmodule

// ----- test/tb.sv -----
// testbench for sample_without_replacement: directed and random draws against a local predictor
`timescale 1ns / 1ps

module tb;

  localparam int IdleLimit   = 20000;
  localparam int RandomDraws = 1400;
  localparam int ReportMax   = 10;

  // one expected draw result
  typedef struct {
    swr_pkg::pick_t pick;
    logic           empty;
  } draw_t;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  swr_pkg::frac_t uniform_fraction;
  logic           restart;
  logic           out_valid;
  logic           out_stall = 1'b0;
  swr_pkg::pick_t picked_index;
  logic           exhausted;
  logic           cfg_valid;
  logic           cfg_ready;
  swr_pkg::size_t population_size;

  // predictor state: remaining indices, how many are left, the programmed size
  swr_pkg::pick_t pool [swr_pkg::MaxPopulation];
  swr_pkg::cnt_t  pool_left;
  swr_pkg::size_t pop_setting;
  draw_t          expected_draws [$];

  int idle_pct = 23;
  int draws_sent;
  int results_checked;
  int exhausted_seen;
  int restarts_sent;
  int settings_written;
  int mismatches;
  int quiet_cycles;

  sample_without_replacement DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .uniform_fraction (uniform_fraction),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .picked_index     (picked_index),
    .exhausted        (exhausted),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .population_size  (population_size)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // refill the pool with 0..n-1, saturating at the list depth
  function automatic void refill_pool();
    for (int i = 0; i < swr_pkg::MaxPopulation; i++) begin
      pool[swr_pkg::addr_t'(i)] = swr_pkg::pick_t'(i);
    end
    if (pop_setting > swr_pkg::size_t'(swr_pkg::MaxPopulation)) begin
      pool_left = swr_pkg::cnt_t'(swr_pkg::MaxPopulation);
    end else begin
      pool_left = swr_pkg::cnt_t'(pop_setting);
    end
  endfunction

  // draw one index from the pool and queue the expected result
  function automatic void predict_draw(input swr_pkg::frac_t u, input logic rs);
    swr_pkg::prod_t prod;
    swr_pkg::cnt_t  pos;
    draw_t          d;
    if (rs) refill_pool();
    if (pool_left == '0) begin
      d.pick  = '0;
      d.empty = 1'b1;
    end else begin
      prod = swr_pkg::prod_t'(pool_left) * swr_pkg::prod_t'(u);
      pos  = swr_pkg::cnt_t'(prod >> swr_pkg::FracW);
      if (pos >= pool_left) pos = pool_left - swr_pkg::cnt_t'(1);
      d.pick  = pool[pos[swr_pkg::AddrW-1:0]];
      d.empty = 1'b0;
      for (int i = int'(pos); i < int'(pool_left) - 1; i++) begin
        pool[swr_pkg::addr_t'(i)] = pool[swr_pkg::addr_t'(i + 1)];
      end
      pool_left = pool_left - swr_pkg::cnt_t'(1);
    end
    expected_draws.push_back(d);
  endfunction

  // random fraction, now and then an extreme
  function automatic swr_pkg::frac_t pick_fraction();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return swr_pkg::frac_t'($urandom);
  endfunction

  // send one draw transaction, with random idle cycles ahead of it
  task automatic draw_one(input swr_pkg::frac_t u, input logic rs);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    uniform_fraction <= u;
    restart          <= rs;
    do @(posedge clk); while (in_stall);
    predict_draw(u, rs);
    draws_sent++;
    if (rs) restarts_sent++;
  endtask

  // program the population size
  task automatic write_population(input swr_pkg::size_t n);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    population_size <= n;
    do @(posedge clk); while (!cfg_ready);
    pop_setting = n;
    settings_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // list straight out of reset, no restart
  task automatic check_reset_list();
    draw_one('0, 1'b0);
    draw_one('1, 1'b0);
    draw_one(32'h8000_0000, 1'b0);
  endtask

  // fraction extremes on a small population
  task automatic check_fraction_extremes();
    drain();
    write_population(swr_pkg::size_t'(16));
    draw_one('0, 1'b1);
    draw_one('1, 1'b0);
    draw_one(32'h0000_0001, 1'b0);
    draw_one(32'h7FFF_FFFF, 1'b0);
    draw_one(32'h8000_0000, 1'b0);
    draw_one('1, 1'b1);
  endtask

  // one index: draw it, then run dry, then restart
  task automatic check_single_index();
    drain();
    write_population(swr_pkg::size_t'(1));
    draw_one('1, 1'b1);
    draw_one('0, 1'b0);
    draw_one('1, 1'b0);
    draw_one('0, 1'b1);
  endtask

  // zero population: a restart leaves nothing to draw
  task automatic check_empty_population();
    drain();
    write_population('0);
    draw_one(32'h1234_5678, 1'b1);
    draw_one('1, 1'b0);
  endtask

  // sizes above the list depth saturate, then the full list
  task automatic check_oversize_population();
    drain();
    write_population('1);
    draw_one('1, 1'b1);
    drain();
    write_population(swr_pkg::size_t'(1025));
    draw_one('0, 1'b1);
    drain();
    write_population(swr_pkg::SizeReset);
    draw_one('1, 1'b1);
  endtask

  // random rounds: set a size, restart, draw sizes up to 48 through and a little past, others 1 to 10 times
  task automatic check_random_draws();
    int             start;
    int             r;
    int             len;
    swr_pkg::size_t n;
    start = draws_sent;
    while (draws_sent - start < RandomDraws) begin
      r = $urandom_range(99);
      if (r < 2) n = '0;
      else if (r < 4) n = swr_pkg::SizeReset;
      else if (r < 5) n = swr_pkg::size_t'($urandom_range(1025, 2047));
      else if (r < 13) n = swr_pkg::size_t'($urandom_range(49, 400));
      else n = swr_pkg::size_t'($urandom_range(1, 48));
      len = (n > 48) ? $urandom_range(1, 10) : int'(n) + $urandom_range(0, 3);
      drain();
      write_population(n);
      // long stretch with no idling on either side
      idle_pct = (draws_sent - start > 500 && draws_sent - start < 800) ? 0 : 23;
      draw_one(pick_fraction(), 1'b1);
      for (int k = 0; k < len; k++) begin
        draw_one(pick_fraction(), $urandom_range(99) < 4);
      end
    end
    idle_pct = 23;
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    draw_t d;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (exhausted) exhausted_seen++;
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result: pick %0d exhausted %0b", picked_index, exhausted);
      end else begin
        d = expected_draws.pop_front();
        if (picked_index !== d.pick || exhausted !== d.empty) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("mismatch at result %0d: expected pick %0d exhausted %0b, got %0d %0b",
                     results_checked, d.pick, d.empty, picked_index, exhausted);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    uniform_fraction = '0;
    restart          = 1'b0;
    cfg_valid        = 1'b0;
    population_size  = swr_pkg::SizeReset;
    pop_setting      = swr_pkg::SizeReset;
    refill_pool();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_reset_list();
    check_fraction_extremes();
    check_single_index();
    check_empty_population();
    check_oversize_population();
    check_random_draws();
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d draws, %0d restarts, %0d exhausted results, %0d size settings",
             draws_sent, restarts_sent, exhausted_seen, settings_written);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
